// ===== sv/fitr_pkg.sv =====
// fitr_pkg: shared types and constants of the frame interval rate tracker
// transaction payload structs, sequencer states, fixed-point limits
// no dependencies
`default_nettype none

package fitr_pkg;

  // ring of per-blank intervals
  localparam int AVG_DEPTH = 4;
  localparam int AVG_PTR_W = $clog2(AVG_DEPTH);
  localparam int SUM_W     = 32 + AVG_PTR_W;

  // shared divider step counts (one quotient bit per cycle)
  localparam int ELAP_STEPS  = 64;
  localparam int RATIO_STEPS = 48;
  localparam int DIV_CNT_W   = 6;

  // Q4.16 scale limits and sync ratio limit
  localparam logic [19:0] SCALE_ONE = 20'd65536;
  localparam logic [19:0] SCALE_MIN = 20'd16384;
  localparam logic [19:0] SCALE_MAX = 20'd524288;
  localparam logic [23:0] SYNC_MAX  = 24'hFFFFFF;
  localparam logic [31:0] U32_MAX   = 32'hFFFFFFFF;

  // register map (byte address bits above the word offset)
  localparam int          CFG_ADDR_W      = 3;
  localparam logic [0:0]  REG_TARGET_IDX  = 1'b0;

  typedef struct packed {
    logic [31:0] frame_origin;
    logic        time_valid;
    logic [63:0] timestamp;
  } fitr_in_t;

  typedef struct packed {
    logic        measured;
    logic [31:0] avg_ticks_per_frame;
    logic [19:0] performance_scale;
    logic [23:0] sync_ratio;
  } fitr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ELAP,
    ST_PUSH,
    ST_RATIO_LD,
    ST_DIV_RATIO,
    ST_UPDATE,
    ST_FIN
  } fitr_state_t;

endpackage

`default_nettype wire

// ===== sv/frame_interval_rate_tracker_unit.sv =====
// frame_interval_rate_tracker_unit: top level of the frame interval rate tracker
// one shared restoring divider under a small sequencer; depends on fitr_pkg
// a measured interval runs the elapsed division, the ring push, the ratio setup, the
// ratio division and the update; otherwise the elapsed division and push are skipped,
// and a zero average also skips the ratio division and update; the shared divider yields
// one quotient bit per cycle; a new item is taken only in idle, but may enter while the
// previous result waits in the output register; reset: synchronous active-low rst_n
// clears control, tracker and target state, not divider or payload; scale returns to 1.0 in Q4.16
`default_nettype none

module frame_interval_rate_tracker_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  fitr_pkg::fitr_in_t          in_data,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output fitr_pkg::fitr_out_t               out_data,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [fitr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import fitr_pkg::*;

  localparam logic [SUM_W-1:0] AVG_HALF = SUM_W'(AVG_DEPTH / 2);
  localparam logic [AVG_PTR_W-1:0] PTR_LAST = AVG_PTR_W'(AVG_DEPTH - 1);

  fitr_state_t            state_r, state_nxt;

  logic [31:0]            target_r;
  logic [63:0]            last_time_r, last_time_nxt;
  logic [31:0]            last_origin_r, last_origin_nxt;
  logic [31:0]            blanks_r, blanks_nxt;
  logic [31:0]            ring_r [AVG_DEPTH];
  logic [31:0]            ring_nxt [AVG_DEPTH];
  logic [AVG_PTR_W-1:0]   ptr_r, ptr_nxt;
  logic                   primed_r, primed_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [31:0]            avg_r, avg_nxt;
  logic [19:0]            scale_r, scale_nxt;
  logic [23:0]            sync_r, sync_nxt;
  logic                   meas_r, meas_nxt;

  // shared divider registers
  logic [63:0]            dvd_r, dvd_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic [31:0]            dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  fitr_out_t              out_r, out_nxt;

  // divider step datapath
  logic [32:0]            rem_sh;
  logic [33:0]            diff;
  logic                   fits;
  logic [31:0]            rem_step;
  logic [63:0]            dvd_step;

  // per-item helpers
  logic [31:0]            blanks_inc;
  logic                   changed;
  logic [31:0]            sample;
  logic [SUM_W-1:0]       sum_avg;
  logic [31:0]            avg_calc;
  logic [47:0]            quot;
  logic [19:0]            ms_clamp;
  logic [23:0]            scale_mix;
  logic                   cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_TARGET_IDX);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_TARGET_IDX) ? target_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 32'd0;
    end else if (cfg_wr) begin
      target_r <= pwdata;
    end
  end

  // restoring division step, one quotient bit per cycle
  assign rem_sh   = {rem_r, dvd_r[63]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign fits     = !diff[33];
  assign rem_step = fits ? diff[31:0] : rem_sh[31:0];
  assign dvd_step = {dvd_r[62:0], fits};

  // per-item helpers
  assign blanks_inc = (blanks_r == U32_MAX) ? U32_MAX : blanks_r + 32'd1;
  assign changed    = (in_data.frame_origin != last_origin_r) && in_data.time_valid;
  assign sample     = (|dvd_r[63:32]) ? U32_MAX : dvd_r[31:0];
  assign sum_avg    = (sum_r + AVG_HALF) / SUM_W'(AVG_DEPTH);
  assign avg_calc   = sum_avg[31:0];
  assign quot       = dvd_r[47:0];

  // clamp of the measured scale and 7/8 old plus 1/8 new smoothing
  always_comb begin
    if (quot < {28'd0, SCALE_MIN}) begin
      ms_clamp = SCALE_MIN;
    end else if (quot > {28'd0, SCALE_MAX}) begin
      ms_clamp = SCALE_MAX;
    end else begin
      ms_clamp = quot[19:0];
    end
    scale_mix = ({1'b0, scale_r, 3'b000} - {4'd0, scale_r}) + {4'd0, ms_clamp};
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: next state and datapath next values
  always_comb begin
    state_nxt       = state_r;
    last_time_nxt   = last_time_r;
    last_origin_nxt = last_origin_r;
    blanks_nxt      = blanks_r;
    ring_nxt        = ring_r;
    ptr_nxt         = ptr_r;
    primed_nxt      = primed_r;
    sum_nxt         = sum_r;
    avg_nxt         = avg_r;
    scale_nxt       = scale_r;
    sync_nxt        = sync_r;
    meas_nxt        = meas_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    dsr_nxt         = dsr_r;
    cnt_nxt         = cnt_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          meas_nxt  = changed && (last_time_r != 64'd0) && (blanks_inc != 32'd0);
          // elapsed ticks over blank count, wraps modulo 2^64
          dvd_nxt   = in_data.timestamp - last_time_r;
          rem_nxt   = 32'd0;
          dsr_nxt   = blanks_inc;
          cnt_nxt   = DIV_CNT_W'(ELAP_STEPS - 1);
          if (changed) begin
            last_origin_nxt = in_data.frame_origin;
            last_time_nxt   = in_data.timestamp;
            blanks_nxt      = 32'd0;
          end else begin
            blanks_nxt      = blanks_inc;
          end
          if (changed && (last_time_r != 64'd0) && (blanks_inc != 32'd0)) begin
            state_nxt = ST_DIV_ELAP;
          end else begin
            state_nxt = ST_RATIO_LD;
          end
        end
      end

      ST_DIV_ELAP: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_PUSH;
        end
      end

      // push the saturated interval into the ring, keep a running sum
      ST_PUSH: begin
        if (!primed_r) begin
          for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_nxt[i] = sample;
          end
          sum_nxt    = SUM_W'({32'd0, sample} * AVG_DEPTH);
          primed_nxt = 1'b1;
          ptr_nxt    = (PTR_LAST == '0) ? '0 : AVG_PTR_W'(1);
        end else begin
          ring_nxt[ptr_r] = sample;
          sum_nxt         = sum_r - {{AVG_PTR_W{1'b0}}, ring_r[ptr_r]}
                            + {{AVG_PTR_W{1'b0}}, sample};
          ptr_nxt         = (ptr_r == PTR_LAST) ? '0 : ptr_r + AVG_PTR_W'(1);
        end
        state_nxt = ST_RATIO_LD;
      end

      // rounded mean, then set up target << 16 over the mean
      ST_RATIO_LD: begin
        avg_nxt = avg_calc;
        dvd_nxt = {target_r, 32'd0};
        rem_nxt = 32'd0;
        dsr_nxt = avg_calc;
        cnt_nxt = DIV_CNT_W'(RATIO_STEPS - 1);
        if (avg_calc == 32'd0) begin
          sync_nxt  = 24'd0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV_RATIO;
        end
      end

      ST_DIV_RATIO: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_UPDATE;
        end
      end

      // saturate sync ratio, smooth scale on a new measurement with a nonzero target
      ST_UPDATE: begin
        sync_nxt = (quot > {24'd0, SYNC_MAX}) ? SYNC_MAX : quot[23:0];
        if (meas_r && (target_r != 32'd0)) begin
          scale_nxt = scale_mix[22:3];
        end
        state_nxt = ST_FIN;
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.measured            = meas_r;
          out_nxt.avg_ticks_per_frame = avg_r;
          out_nxt.performance_scale   = scale_r;
          out_nxt.sync_ratio          = sync_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r   <= 64'd0;
      last_origin_r <= 32'd0;
      blanks_r      <= 32'd0;
      ptr_r         <= '0;
      primed_r      <= 1'b0;
      sum_r         <= '0;
      avg_r         <= 32'd0;
      scale_r       <= SCALE_ONE;
      sync_r        <= 24'd0;
      meas_r        <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= 32'd0;
      end
    end else begin
      last_time_r   <= last_time_nxt;
      last_origin_r <= last_origin_nxt;
      blanks_r      <= blanks_nxt;
      ptr_r         <= ptr_nxt;
      primed_r      <= primed_nxt;
      sum_r         <= sum_nxt;
      avg_r         <= avg_nxt;
      scale_r       <= scale_nxt;
      sync_r        <= sync_nxt;
      meas_r        <= meas_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      ring_r        <= ring_nxt;
    end
  end

  // divider and output payload
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/sv/frame_interval_rate_tracker_unit_tb.sv =====
// frame_interval_rate_tracker_unit_tb: self-checking bench for the frame interval rate tracker
// drives vertical blank transactions and target writes, predicts every report in place
// depends on fitr_pkg and frame_interval_rate_tracker_unit
`default_nettype none

module frame_interval_rate_tracker_unit_tb;
  import fitr_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int HOLD_OFF_LEN   = 400;

  // byte addresses of the register map
  localparam logic [CFG_ADDR_W-1:0] ADDR_TARGET   = CFG_ADDR_W'(4 * REG_TARGET_IDX);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4 * (REG_TARGET_IDX + 1));

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  fitr_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  fitr_out_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // tracker state as predicted by the bench
  bit [31:0] trk_target;
  bit [63:0] trk_last_stamp;
  bit [31:0] trk_last_origin;
  bit [31:0] trk_blanks;
  bit [31:0] trk_ring [AVG_DEPTH];
  int        trk_ptr;
  bit        trk_primed;
  bit [31:0] trk_avg;
  bit [19:0] trk_scale;

  // stimulus state: host tick counter and current video origin
  bit [63:0] host_ticks;
  bit [31:0] cur_origin;
  int        blanks_to_flip;
  bit        steady;
  int        stall_len;
  int        error_count;
  int        quiet_cycles;

  fitr_out_t pending_reports[$];

  frame_interval_rate_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic fitr_in_t mk_blank(input bit [31:0] origin, input bit valid,
                                        input bit [63:0] stamp);
    fitr_in_t b;
    b.frame_origin = origin;
    b.time_valid   = valid;
    b.timestamp    = stamp;
    return b;
  endfunction

  // advance the tracker by one blank and return the report it produces
  function automatic fitr_out_t predict_blank(input fitr_in_t b);
    fitr_out_t r;
    bit [63:0] elapsed;
    bit [63:0] per_blank;
    bit [63:0] sum;
    bit [63:0] ratio;
    bit [31:0] sample;
    r = '0;
    if (trk_blanks != U32_MAX) trk_blanks++;
    if (b.frame_origin != trk_last_origin && b.time_valid) begin
      if (trk_last_stamp != 64'd0 && trk_blanks != 32'd0) begin
        elapsed   = b.timestamp - trk_last_stamp;
        per_blank = elapsed / {32'd0, trk_blanks};
        sample    = (per_blank > {32'd0, U32_MAX}) ? U32_MAX : per_blank[31:0];
        // first interval fills the whole ring
        if (!trk_primed) begin
          foreach (trk_ring[i]) trk_ring[i] = sample;
          trk_primed = 1'b1;
          trk_ptr    = 0;
        end
        trk_ring[trk_ptr] = sample;
        trk_ptr = (trk_ptr + 1) % AVG_DEPTH;
        sum = '0;
        foreach (trk_ring[i]) sum += {32'd0, trk_ring[i]};
        trk_avg = 32'((sum + 64'(AVG_DEPTH / 2)) / 64'(AVG_DEPTH));
        r.measured = 1'b1;
        // clamped scale, smoothed 7/8 old plus 1/8 new
        if (trk_avg != 32'd0 && trk_target != 32'd0) begin
          ratio = {16'd0, trk_target, 16'd0} / {32'd0, trk_avg};
          if (ratio < {44'd0, SCALE_MIN}) ratio = {44'd0, SCALE_MIN};
          if (ratio > {44'd0, SCALE_MAX}) ratio = {44'd0, SCALE_MAX};
          trk_scale = 20'((64'd7 * {44'd0, trk_scale} + ratio) >> 3);
        end
      end
      trk_last_origin = b.frame_origin;
      trk_last_stamp  = b.timestamp;
      trk_blanks      = '0;
    end
    ratio = '0;
    if (trk_avg != 32'd0) begin
      ratio = {16'd0, trk_target, 16'd0} / {32'd0, trk_avg};
      if (ratio > {40'd0, SYNC_MAX}) ratio = {40'd0, SYNC_MAX};
    end
    r.avg_ticks_per_frame = trk_avg;
    r.performance_scale   = trk_scale;
    r.sync_ratio          = ratio[23:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic check_report(input fitr_out_t got);
    fitr_out_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("unexpected transaction", 64'(got.avg_ticks_per_frame), 64'd0);
      return;
    end
    want = pending_reports.pop_front();
    if (got.measured !== want.measured)
      report_mismatch("measured", 64'(got.measured), 64'(want.measured));
    if (got.avg_ticks_per_frame !== want.avg_ticks_per_frame)
      report_mismatch("avg_ticks_per_frame", 64'(got.avg_ticks_per_frame),
                      64'(want.avg_ticks_per_frame));
    if (got.performance_scale !== want.performance_scale)
      report_mismatch("performance_scale", 64'(got.performance_scale),
                      64'(want.performance_scale));
    if (got.sync_ratio !== want.sync_ratio)
      report_mismatch("sync_ratio", 64'(got.sync_ratio), 64'(want.sync_ratio));
  endtask

  // result side: compare every accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_report(out_data);
  end

  // receiver: random stalls, steady stretches and a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_len != 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
        stall_len = 0;
      end
      out_ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one blank, wait for acceptance, queue its prediction
  task automatic send_blank(input fitr_in_t b);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 18) gap++;
      if ($urandom_range(99) < 4) gap += $urandom_range(1, 150);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(predict_blank(b));
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TARGET) trk_target = data;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) report_mismatch("prdata", 64'(prdata), 64'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // well-formed blanks: ticks advance by a jittered nominal, origin flips every 1..4 blanks
  task automatic stream_frames(input int count, input bit [63:0] nominal);
    fitr_in_t  b;
    bit [63:0] spread;
    bit [31:0] next_origin;
    repeat (count) begin
      if ($urandom_range(99) < 3) begin
        nominal = nominal * 64'($urandom_range(1, 4)) / 64'($urandom_range(1, 4));
        if (nominal == 64'd0) nominal = 64'd1;
      end
      spread = nominal >> 3;
      host_ticks += nominal - (spread >> 1) + rand64() % (spread + 64'd1);
      if (blanks_to_flip == 0) begin
        next_origin = $urandom;
        if (next_origin == cur_origin) next_origin ^= 32'h1;
        cur_origin     = next_origin;
        blanks_to_flip = $urandom_range(0, 3);
      end else begin
        blanks_to_flip--;
      end
      b = mk_blank(cur_origin, $urandom_range(99) >= 4, host_ticks);
      send_blank(b);
    end
  endtask

  // reset value, origin and timestamp extremes, each special case in turn
  task automatic test_directed_cases();
    cfg_read_check(ADDR_TARGET, 32'd0);
    cfg_write(ADDR_TARGET, 32'd1000);
    cfg_read_check(ADDR_TARGET, 32'd1000);
    // origin unchanged from reset
    send_blank(mk_blank(32'd0, 1'b1, 64'd500));
    // origin changes without a valid time
    send_blank(mk_blank(32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
    // no previous time, then a zero stamp leaves the next change unmeasured
    send_blank(mk_blank(32'd1, 1'b1, 64'd0));
    send_blank(mk_blank(32'd2, 1'b1, 64'd1000));
    send_blank(mk_blank(32'd2, 1'b1, 64'd2000));
    // first sample seeds the ring
    send_blank(mk_blank(32'd3, 1'b1, 64'd3000));
    // short intervals push the scale to its upper clamp
    send_blank(mk_blank(32'd4, 1'b1, 64'd3250));
    send_blank(mk_blank(32'd5, 1'b1, 64'd3260));
    send_blank(mk_blank(32'd6, 1'b1, 64'd3261));
    send_blank(mk_blank(32'd7, 1'b1, 64'd3261));
    // time going backwards wraps, interval saturates, scale hits lower clamp
    send_blank(mk_blank(32'd8, 1'b1, 64'd100));
    send_blank(mk_blank(32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    // zero intervals drive the average to zero
    send_blank(mk_blank(32'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_blank(mk_blank(32'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_blank(mk_blank(32'd2, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_blank(mk_blank(32'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    // several blanks per flip, counted across the wrap of the tick counter
    send_blank(mk_blank(32'd3, 1'b1, 64'd5));
    send_blank(mk_blank(32'd3, 1'b0, 64'd7));
    send_blank(mk_blank(32'd4, 1'b0, 64'd9));
    send_blank(mk_blank(32'd4, 1'b1, 64'd899));
    send_blank(mk_blank(32'd5, 1'b1, 64'd1799));
    wait_for_reports();
  endtask

  task automatic test_zero_target();
    cfg_write(ADDR_TARGET, 32'd0);
    stream_frames(40, 64'd50000);
    wait_for_reports();
  endtask

  task automatic test_unmapped_register();
    cfg_write(ADDR_TARGET, 32'd33333);
    cfg_write(ADDR_UNMAPPED, 32'h5A5A_A5A5);
    cfg_read_check(ADDR_TARGET, 32'd33333);
    stream_frames(30, 64'd33000);
    wait_for_reports();
  endtask

  // saturated sync ratio, lower clamp, saturated intervals
  task automatic test_extreme_targets();
    cfg_write(ADDR_TARGET, U32_MAX);
    stream_frames(40, 64'd3);
    wait_for_reports();
    cfg_write(ADDR_TARGET, 32'd1);
    stream_frames(40, 64'd1000000);
    wait_for_reports();
    cfg_write(ADDR_TARGET, U32_MAX);
    stream_frames(40, 64'h4_0000_0000);
    wait_for_reports();
  endtask

  // receiver holds off while blanks keep coming, so the input stalls
  task automatic test_output_backpressure();
    cfg_write(ADDR_TARGET, 32'd16000);
    stall_len = HOLD_OFF_LEN;
    stream_frames(8, 64'd16500);
    wait_for_reports();
  endtask

  // random transactions, backwards and zero stamps mixed into a live stream
  task automatic test_noise_and_broken_sequences();
    fitr_in_t b;
    int       pick;
    cfg_write(ADDR_TARGET, $urandom_range(1000, 400000));
    repeat (150) begin
      pick = $urandom_range(99);
      if (pick >= 65) begin
        stream_frames(1, 64'd20000);
        continue;
      end
      if (pick < 35) begin
        b = mk_blank(($urandom_range(3) == 0) ? cur_origin : $urandom,
                     1'($urandom_range(1)), rand64());
      end else if (pick < 55) begin
        b = mk_blank(cur_origin + $urandom_range(1, 7), 1'b1, host_ticks - {32'd0, $urandom});
      end else begin
        b = mk_blank(cur_origin + 32'd1, 1'b1, 64'd0);
      end
      cur_origin = b.frame_origin;
      host_ticks = b.timestamp;
      send_blank(b);
    end
    wait_for_reports();
  endtask

  // segments of well-formed blanks, each under a fresh target; first one without idling
  task automatic test_random_tracking();
    bit [63:0] nominal;
    bit [63:0] tgt;
    for (int seg = 0; seg < 10; seg++) begin
      case ($urandom_range(9))
        0:       nominal = 64'($urandom_range(1, 64));
        6, 7:    nominal = {32'd0, $urandom};
        8:       nominal = {28'd0, 4'($urandom_range(1, 15)), $urandom};
        9:       nominal = 64'($urandom_range(20000, 100000));
        default: nominal = 64'($urandom_range(1000, 2000000));
      endcase
      tgt = (nominal << $urandom_range(0, 4)) >> $urandom_range(0, 4);
      if (tgt > {32'd0, U32_MAX}) tgt = {32'd0, U32_MAX};
      case ($urandom_range(9))
        0:       tgt = 64'd0;
        1:       tgt = {32'd0, U32_MAX};
        default: ;
      endcase
      cfg_write(ADDR_TARGET, tgt[31:0]);
      steady = (seg == 0);
      stream_frames(150, nominal);
      wait_for_reports();
      steady = 1'b0;
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    stall_len    = 0;
    error_count  = 0;
    quiet_cycles = 0;

    // predicted state after reset
    trk_target      = '0;
    trk_last_stamp  = '0;
    trk_last_origin = '0;
    trk_blanks      = '0;
    foreach (trk_ring[i]) trk_ring[i] = '0;
    trk_ptr         = 0;
    trk_primed      = 1'b0;
    trk_avg         = '0;
    trk_scale       = SCALE_ONE;

    host_ticks     = rand64();
    cur_origin     = $urandom;
    blanks_to_flip = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_zero_target();
    test_unmapped_register();
    test_extreme_targets();
    test_output_backpressure();
    test_noise_and_broken_sequences();
    test_random_tracking();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
